// ===== src/trajectory_table_interpolator_top_assert.svh =====
`ifndef TRAJECTORY_TABLE_INTERPOLATOR_TOP_ASSERT_SVH
`define TRAJECTORY_TABLE_INTERPOLATOR_TOP_ASSERT_SVH
// clocked implication check with synchronous reset disable
`define TTI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// check that also holds while reset is asserted
`define TTI_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== src/tti_pkg.sv =====
package tti_pkg;
   localparam int MaxWaypoints = 64;
   localparam int IdxW = $clog2(MaxWaypoints);
   localparam int CntW = IdxW + 1;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // one memory word: a whole waypoint
   localparam int WayW = 32 * 6 + 16 * 2;

   typedef struct packed {
      logic [31:0]        stamp;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [15:0] yaw;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [15:0] vyaw;
      logic [31:0]        cum;
   } way_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [31:0]        stamp;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] pos_yaw;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [15:0] vel_yaw;
      logic [31:0]        elapsed_time;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [15:0] target_yaw;
      logic signed [31:0] target_vx;
      logic signed [31:0] target_vy;
      logic signed [15:0] target_vyaw;
      logic [31:0]        distance;
      logic [5:0]         waypoint_index;
   } rsp_type;

   // divider handshake
   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [32:0] den;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quo;
   } div_rsp_type;
endpackage

// ===== src/tti_if.sv =====
interface tti_req_if;
   import tti_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tti_rsp_if;
   import tti_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tti_csr_if;
   logic        valid;
   logic        ready;
   logic [23:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== src/tti_ram.sv =====
module tti_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== src/tti_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit numerator.
module tti_div (
   input  logic                      clock,
   input  logic                      reset,
   input  tti_pkg::div_req_type      div_req,
   output tti_pkg::div_rsp_type      div_rsp
);
   import tti_pkg::*;

   logic [63:0] quo_ff, quo_in;
   logic [33:0] rem_ff, rem_in;
   logic [32:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] trial;
   logic [34:0] diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[32:0], quo_ff[63]};
      diff    = {1'b0, trial} - {2'b00, den_ff};
      if (div_req.start) begin
         quo_in  = div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[34]) begin
            rem_in = diff[33:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;
endmodule

// ===== src/tti_sqrt.sv =====
// Bit-pair integer square root of a 64-bit value, one result bit per cycle.
module tti_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        busy,
   output logic        done,
   output logic [31:0] root
);
   logic [63:0] rad_ff, rad_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] trial;
   logic [34:0] diff;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], rad_ff[63:62]};
      diff    = {1'b0, trial} - {1'b0, root_ff, 2'b01};
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[61:0], 2'b00};
         if (!diff[34]) begin
            rem_in  = diff[33:0];
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = trial;
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = root_ff;
endmodule

// ===== src/tti_ctrl.sv =====
`include "trajectory_table_interpolator_top_assert.svh"

module tti_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   tti_req_if.sink               req,
   tti_rsp_if.source             rsp,
   tti_csr_if.sink               csr,
   output logic                  mem_we,
   output logic [tti_pkg::IdxW-1:0] mem_waddr,
   output tti_pkg::way_type      mem_wdata,
   output logic [tti_pkg::IdxW-1:0] mem_raddr,
   input  tti_pkg::way_type      mem_rdata,
   output tti_pkg::div_req_type  div_req,
   input  tti_pkg::div_rsp_type  div_rsp,
   output logic                  sq_start,
   output logic [63:0]           sq_radicand,
   input  logic                  sq_done,
   input  logic [31:0]           sq_root
);
   import tti_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_APRD   = 14'b00000000000010,
      S_APSQ1  = 14'b00000000000100,
      S_APSQ2  = 14'b00000000001000,
      S_APSQ   = 14'b00000000010000,
      S_APWR   = 14'b00000000100000,
      S_QRD0   = 14'b00000001000000,
      S_SCAN   = 14'b00000010000000,
      S_RDA    = 14'b00000100000000,
      S_RDB    = 14'b00001000000000,
      S_LERP   = 14'b00010000000000,
      S_LDIV   = 14'b00100000000000,
      S_CUM    = 14'b01000000000000,
      S_OUT    = 14'b10000000000000
   } state_type;

   state_type   state_ff, state_in;
   req_type     item_ff, item_in;
   rsp_type     res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] look_ff, look_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [31:0] run_ff, run_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [CntW-1:0] passed_ff, passed_in;
   logic [33:0] cur_ff, cur_in;
   logic [33:0] tt_ff, tt_in;
   way_type     wa_ff, wa_in;
   way_type     wb_ff, wb_in;
   logic [2:0]  lane_ff, lane_in;
   logic [63:0] prod_ff, prod_in;
   logic        neg_ff, neg_in;
   logic signed [32:0] v0_ff, v0_in;
   logic [63:0] acc_ff, acc_in;
   logic [IdxW-1:0] last_idx;
   logic [32:0] den;
   logic [32:0] num;
   logic signed [32:0] lv0, lv1, dlt;
   logic [32:0] mag;
   logic [32:0] dmag;
   logic [32:0] sum33;
   logic [63:0] res64;
   logic [34:0] run_sum;

   assign last_idx = IdxW'(count_ff - CntW'(1));
   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = res_ff;
   assign den = {1'b0, wb_ff.stamp} - {1'b0, wa_ff.stamp};
   assign num = cur_ff[32:0] - {1'b0, wa_ff.stamp};

   // lane values
   always_comb begin
      case (lane_ff)
         3'd0: begin lv0 = 33'(wa_ff.x); lv1 = 33'(wb_ff.x); end
         3'd1: begin lv0 = 33'(wa_ff.y); lv1 = 33'(wb_ff.y); end
         3'd2: begin lv0 = 33'(wa_ff.yaw); lv1 = 33'(wb_ff.yaw); end
         3'd3: begin lv0 = 33'(wa_ff.vx); lv1 = 33'(wb_ff.vx); end
         3'd4: begin lv0 = 33'(wa_ff.vy); lv1 = 33'(wb_ff.vy); end
         default: begin lv0 = 33'(wa_ff.vyaw); lv1 = 33'(wb_ff.vyaw); end
      endcase
      dlt = lv1 - lv0;
      mag = dlt[32] ? 33'(-dlt) : dlt;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      look_in      = look_ff;
      count_in     = count_ff;
      run_in       = run_ff;
      idx_in       = idx_ff;
      passed_in    = passed_ff;
      cur_in       = cur_ff;
      tt_in        = tt_ff;
      wa_in        = wa_ff;
      wb_in        = wb_ff;
      lane_in      = lane_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      v0_in        = v0_ff;
      acc_in       = acc_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[IdxW-1:0];
      mem_wdata    = '0;
      mem_raddr    = idx_ff;
      div_req      = '0;
      sq_start     = 1'b0;
      sq_radicand  = acc_ff;
      sum33        = '0;
      dmag         = '0;
      res64        = '0;
      run_sum      = '0;
      if (csr.valid) begin
         look_in = csr.data;
      end
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               item_in = req.data;
               res_in  = '0;
               idx_in  = '0;
               passed_in = '0;
               case (req.data.cmd)
                  CMD_CLEAR: begin
                     count_in = '0;
                     run_in   = '0;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_APPEND: begin
                     if (count_ff >= CntW'(MaxWaypoints)) begin
                        res_in.status = ST_FULL;
                        res_in.distance = run_ff;
                        res_in.waypoint_index = 6'(last_idx);
                        rsp_valid_in = 1'b1;
                     end else if (count_ff == '0) begin
                        state_in = S_APWR;
                     end else begin
                        idx_in   = last_idx;
                        state_in = S_APRD;
                     end
                  end
                  CMD_QUERY: begin
                     if (count_ff == '0) begin
                        res_in.status = ST_EMPTY;
                        rsp_valid_in = 1'b1;
                     end else begin
                        idx_in   = '0;
                        state_in = S_QRD0;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_APRD: begin
            state_in = S_APSQ1;
         end
         S_APSQ1: begin
            // |dx|^2 into prod, |dy| stashed in v0
            sum33   = 33'(item_ff.pos_x) - 33'(mem_rdata.x);
            dmag    = sum33[32] ? 33'(-sum33) : sum33;
            prod_in = 64'(dmag) * 64'(dmag);
            sum33   = 33'(item_ff.pos_y) - 33'(mem_rdata.y);
            v0_in   = sum33[32] ? 33'(-sum33) : sum33;
            state_in = S_APSQ2;
         end
         S_APSQ2: begin
            acc_in   = 64'(v0_ff) * 64'(v0_ff);
            state_in = S_APSQ;
            lane_in  = 3'd0;
         end
         S_APSQ: begin
            if (lane_ff == 3'd0) begin
               res64 = prod_ff + acc_ff;
               lane_in = 3'd1;
               if (res64 < prod_ff) begin
                  // root of an overflowing sum saturates
                  acc_in = '0;
                  prod_in = 64'hFFFF_FFFF;
                  state_in = S_APWR;
                  neg_in = 1'b1;
               end else begin
                  acc_in = res64;
                  sq_radicand = res64;
                  sq_start = 1'b1;
                  neg_in = 1'b0;
               end
            end else if (sq_done) begin
               prod_in  = 64'(sq_root);
               neg_in   = 1'b1;
               state_in = S_APWR;
            end
         end
         S_APWR: begin
            run_sum = neg_ff && count_ff != '0 ? 35'(run_ff) + 35'(prod_ff[32:0]) : 35'(run_ff);
            run_in  = run_sum[34:32] != 3'd0 ? 32'hFFFF_FFFF : run_sum[31:0];
            mem_we  = 1'b1;
            mem_wdata.stamp = item_ff.stamp;
            mem_wdata.x     = item_ff.pos_x;
            mem_wdata.y     = item_ff.pos_y;
            mem_wdata.yaw   = item_ff.pos_yaw;
            mem_wdata.vx    = item_ff.vel_x;
            mem_wdata.vy    = item_ff.vel_y;
            mem_wdata.vyaw  = item_ff.vel_yaw;
            mem_wdata.cum   = run_in;
            res_in.distance = run_in;
            res_in.waypoint_index = 6'(count_ff);
            count_in = count_ff + CntW'(1);
            neg_in   = 1'b0;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         S_QRD0: begin
            // entry 0 read issued this cycle
            mem_raddr = '0;
            idx_in   = '0;
            state_in = S_SCAN;
            lane_in  = 3'd0;
         end
         S_SCAN: begin
            if (lane_ff == 3'd0) begin
               cur_in = 34'(mem_rdata.stamp) + 34'(item_ff.elapsed_time);
               tt_in  = 34'(mem_rdata.stamp) + 34'(item_ff.elapsed_time) + 34'(look_ff);
               lane_in = 3'd1;
               if (last_idx == '0) begin
                  state_in = S_RDA;
               end else begin
                  mem_raddr = '0;
               end
            end else begin
               // mem_rdata is the stored entry at idx_ff
               if (34'(mem_rdata.stamp) < tt_ff) begin
                  passed_in = passed_ff + CntW'(1);
               end
               if (34'(mem_rdata.stamp) > tt_ff || idx_ff + IdxW'(1) == last_idx) begin
                  if (34'(mem_rdata.stamp) <= tt_ff) begin
                     idx_in = idx_ff + IdxW'(1);
                  end
                  state_in = S_RDA;
               end else begin
                  idx_in = idx_ff + IdxW'(1);
                  mem_raddr = idx_ff + IdxW'(1);
               end
            end
         end
         S_RDA: begin
            mem_raddr = idx_ff == '0 ? '0 : idx_ff - IdxW'(1);
            state_in  = S_RDB;
            lane_in   = 3'd0;
         end
         S_RDB: begin
            if (lane_ff == 3'd0) begin
               wa_in = mem_rdata;
               mem_raddr = idx_ff;
               lane_in = 3'd1;
            end else begin
               wb_in = mem_rdata;
               lane_in = 3'd0;
               state_in = S_LERP;
            end
         end
         S_LERP: begin
            // per-lane: clamp or set up the divide
            if ({1'b0, cur_ff} <= 35'(wa_ff.stamp)) begin
               v0_in = lv0;
               acc_in = 64'(lv0);
               state_in = S_LDIV;
               neg_in = 1'b1;
            end else if (cur_ff >= 34'(wb_ff.stamp)) begin
               acc_in = 64'(lv1);
               state_in = S_LDIV;
               neg_in = 1'b1;
            end else begin
               prod_in = 64'(mag) * 64'(num[31:0]);
               v0_in   = lv0;
               neg_in  = 1'b0;
               acc_in  = {63'd0, dlt[32]};
               state_in = S_LDIV;
               lane_in = lane_ff;
            end
         end
         S_LDIV: begin
            if (neg_ff) begin
               // clamped value in acc
               res64 = acc_ff;
               neg_in = 1'b0;
            end else if (!div_rsp.busy && !div_rsp.done) begin
               div_req.start = 1'b1;
               div_req.num   = prod_ff + 64'(den[32:1]);
               div_req.den   = den;
            end
            if (neg_ff || div_rsp.done) begin
               if (!neg_ff) begin
                  res64 = acc_ff[0] ? 64'(v0_ff) - div_rsp.quo : 64'(v0_ff) + div_rsp.quo;
               end
               case (lane_ff)
                  3'd0: res_in.target_x = res64[31:0];
                  3'd1: res_in.target_y = res64[31:0];
                  3'd2: res_in.target_yaw = res64[15:0];
                  3'd3: res_in.target_vx = res64[31:0];
                  3'd4: res_in.target_vy = res64[31:0];
                  default: res_in.target_vyaw = res64[15:0];
               endcase
               if (lane_ff == 3'd5) begin
                  mem_raddr = passed_ff == '0 ? '0 : IdxW'(passed_ff - CntW'(1));
                  state_in = S_CUM;
               end else begin
                  lane_in = lane_ff + 3'd1;
                  state_in = S_LERP;
               end
            end
         end
         S_CUM: begin
            // hold the passed entry on the read port for S_OUT
            mem_raddr = passed_ff == '0 ? '0 : IdxW'(passed_ff - CntW'(1));
            state_in = S_OUT;
         end
         S_OUT: begin
            res_in.distance = mem_rdata.cum;
            res_in.waypoint_index = passed_ff == '0 ? 6'd0 : 6'(passed_ff - CntW'(1));
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         look_ff      <= '0;
         count_ff     <= '0;
         run_ff       <= '0;
         neg_ff       <= 1'b0;
         lane_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         look_ff      <= look_in;
         count_ff     <= count_in;
         run_ff       <= run_in;
         neg_ff       <= neg_in;
         lane_ff      <= lane_in;
      end
      item_ff   <= item_in;
      res_ff    <= res_in;
      idx_ff    <= idx_in;
      passed_ff <= passed_in;
      cur_ff    <= cur_in;
      tt_ff     <= tt_in;
      wa_ff     <= wa_in;
      wb_ff     <= wb_in;
      prod_ff   <= prod_in;
      v0_ff     <= v0_in;
      acc_ff    <= acc_in;
   end

   `TTI_ASSERT(a_count_range, clock, reset, count_ff <= CntW'(MaxWaypoints),
      "waypoint count beyond store size")
   `TTI_ASSERT(a_write_idle, clock, reset, mem_we |-> state_ff == S_APWR,
      "store written outside append")
   `TTI_ASSERT(a_rsp_hold, clock, reset, rsp_valid_ff && !rsp.ready |=> rsp_valid_ff,
      "result dropped before transfer")
   `TTI_ASSERT_ALWAYS(a_onehot, clock, $onehot(state_ff) || reset,
      "state not one-hot")
endmodule

// ===== src/trajectory_table_interpolator_top.sv =====
// Clear, unused command, empty query, store-full append: result 1 cycle after transfer.
// Append: straight to write back on an empty store, else two squares, a 32-step root, write back.
// Query: a stamp scan of up to 63 entries (one read a cycle), then the two segment reads,
// then six lanes, each clamped to an end value or interpolated with the 64-step divider.
// One item at a time; the next transfer is taken once the result has left.
// Synchronous reset empties the store and clears lookahead; no clearing pass.
module trajectory_table_interpolator_top (
   input logic       clock,
   input logic       reset,
   tti_req_if.sink   req,
   tti_rsp_if.source rsp,
   tti_csr_if.sink   csr
);
   import tti_pkg::*;

   logic            mem_we;
   logic [IdxW-1:0] mem_waddr;
   logic [IdxW-1:0] mem_raddr;
   way_type         mem_wdata;
   way_type         mem_rdata;
   div_req_type     div_req;
   div_rsp_type     div_rsp;
   logic            sq_start;
   logic [63:0]     sq_radicand;
   logic            sq_busy;
   logic            sq_done;
   logic [31:0]     sq_root;
   logic [WayW-1:0] rd_raw;

   assign mem_rdata = way_type'(rd_raw);

   tti_ram #(.Width(WayW), .Depth(MaxWaypoints)) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (WayW'(mem_wdata)),
      .rd_addr (mem_raddr),
      .rd_data (rd_raw)
   );

   tti_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   tti_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_radicand),
      .busy     (sq_busy),
      .done     (sq_done),
      .root     (sq_root)
   );

   tti_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr         (csr),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .mem_raddr   (mem_raddr),
      .mem_rdata   (mem_rdata),
      .div_req     (div_req),
      .div_rsp     (div_rsp),
      .sq_start    (sq_start),
      .sq_radicand (sq_radicand),
      .sq_done     (sq_done || (sq_busy && 1'b0)),
      .sq_root     (sq_root)
   );
endmodule
